// ===== design/mkh_pkg.sv =====
// ----------------------------------------------------------------------------
// mkh_pkg
// Shared types, codes and constants of the k-mins MinHash signature block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mkh_pkg;

  // Slot count and derived widths
  localparam int MAX_HASHES = 64;
  localparam int CNT_W      = $clog2(MAX_HASHES + 1);

  // Field widths
  localparam int SLOT_W  = 6;
  localparam int COEF_W  = 30;
  localparam int TOKEN_W = 16;
  localparam int HASH_W  = 31;
  localparam int RANGE_W = 30;
  localparam int HC_W    = 7;

  // Config port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = CFG_IDX_W'(1);

  localparam logic [HC_W-1:0]    HASH_COUNT_RST  = HC_W'(64);
  localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = RANGE_W'(998244352);

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TOKEN = 1'b1;

  // Arithmetic constants
  localparam logic [COEF_W-1:0] PRIME_MOD  = COEF_W'(998244353);
  localparam logic [HASH_W-1:0] EMPTY_HASH = {HASH_W{1'b1}};
  // floor(2^49 / p), used to estimate the quotient of a 46-bit value by p
  localparam int RECIP_P_SHIFT = 20;
  localparam int RECIP_P_W     = 20;
  localparam logic [RECIP_P_W-1:0] RECIP_P =
    RECIP_P_W'((64'd1 << (29 + RECIP_P_SHIFT)) / 64'(PRIME_MOD));
  // floor(2^60 / m) for the second reduction
  localparam int RECIP_SHIFT = 60;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP_LO_W  = 31;

  // Pipeline depth of one cell (register stages before the update)
  localparam int CELL_STAGES = 11;
  localparam int WAIT_CYCLES = MAX_HASHES + CELL_STAGES + 1;
  localparam int WAIT_W      = $clog2(WAIT_CYCLES + 1);

  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  slot_index;
    logic [COEF_W-1:0]  coef_mul;
    logic [COEF_W-1:0]  coef_add;
    logic [TOKEN_W-1:0] token;
    logic               last_token;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  out_slot;
    logic [TOKEN_W-1:0] signature_token;
    logic [HASH_W-1:0]  min_hash;
    logic               last_of_run;
  } out_item_t;

  // Running minimum of one slot
  typedef struct packed {
    logic [HASH_W-1:0]  min_hash;
    logic [TOKEN_W-1:0] token;
  } sig_t;

  localparam sig_t EMPTY_SIG = '{min_hash: EMPTY_HASH, token: '0};

  // Readout control broadcast to all cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_WAIT,
    ST_READ
  } state_t;

endpackage

// ===== design/mkh_recip.sv =====
// ----------------------------------------------------------------------------
// mkh_recip
// Bit-serial reciprocal unit: computes floor(2^60 / m), one quotient bit per
// cycle, restarted on reset and on every write of m.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkh_recip (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [mkh_pkg::RANGE_W-1:0]        divisor,
  output logic                               busy,
  output logic [mkh_pkg::RECIP_W-1:0]        recip
);

  localparam int CNT_W = $clog2(mkh_pkg::RECIP_W);

  logic                          busy_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [mkh_pkg::RANGE_W-1:0]   rem_r, rem_nxt;
  logic [mkh_pkg::RECIP_W-1:0]   quo_r, quo_nxt;
  logic [mkh_pkg::RANGE_W:0]     rem_sh;
  logic                          num_bit;
  logic                          q_bit;

  // numerator is a single one at the top bit
  assign num_bit = (cnt_r == CNT_W'(mkh_pkg::RECIP_SHIFT));
  assign rem_sh  = {rem_r, num_bit};
  assign q_bit   = (rem_sh >= {1'b0, divisor});

  always_comb begin
    quo_nxt = {quo_r[mkh_pkg::RECIP_W-2:0], q_bit};
    if (q_bit) begin
      rem_nxt = mkh_pkg::RANGE_W'(rem_sh - {1'b0, divisor});
    end else begin
      rem_nxt = rem_sh[mkh_pkg::RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(mkh_pkg::RECIP_SHIFT);
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      quo_r <= quo_nxt;
    end
  end

  assign busy  = busy_r;
  assign recip = quo_r;

endmodule

// ===== design/mkh_cell.sv =====
// ----------------------------------------------------------------------------
// mkh_cell
// One hash slot: holds its coefficients and running minimum, hashes every
// token that passes and hands the item on to the next cell each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkh_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mkh_pkg::SLOT_W-1:0]    cell_id,
  input  logic                          active,
  input  logic [mkh_pkg::RANGE_W-1:0]   range_limit,
  input  logic [mkh_pkg::RECIP_W-1:0]   recip,
  input  logic                          item_in_valid,
  input  mkh_pkg::in_item_t             item_in,
  output logic                          item_out_valid,
  output mkh_pkg::in_item_t             item_out,
  input  mkh_pkg::cell_ctl_t            ctl,
  input  mkh_pkg::sig_t                 sig_in,
  output mkh_pkg::sig_t                 sig_out
);

  localparam int CW = mkh_pkg::COEF_W;
  localparam int TW = mkh_pkg::TOKEN_W;
  localparam int NS = mkh_pkg::CELL_STAGES;

  // pass-through
  logic              item_vld_r;
  mkh_pkg::in_item_t item_r;

  // coefficients
  logic [CW-1:0] mul_r, add_r;

  // hash pipeline
  logic [NS:1]   vld_r;
  logic [TW-1:0] tok_r [1:NS];
  logic [45:0]   v1_r;
  logic [36:0]   qp2_r;
  logic [31:0]   v2_r, v3_r, qm3_r;
  logic [30:0]   r4_r;
  logic [CW-1:0] h5_r, h6_r, h7_r, h8_r, h9_r, h10_r, h11_r;
  logic [60:0]   pl6_r;
  logic [59:0]   ph7_r;
  logic [29:0]   plh7_r;
  logic [29:0]   q8_r;
  logic [30:0]   qm9_r, r10_r;

  mkh_pkg::sig_t sig_r;

  logic [45:0] v1_nxt;
  logic [36:0] qp2_nxt;
  logic [46:0] qm3_full;
  logic [31:0] r4_full;
  logic [CW-1:0] h5_nxt, h11_nxt;
  logic [60:0] pl6_nxt;
  logic [59:0] ph7_nxt;
  logic [60:0] sum8;
  logic [59:0] qm9_full;
  logic        take;

  always_comb begin
    v1_nxt   = 46'(item_in.token) * 46'(mul_r) + 46'(add_r);
    qp2_nxt  = 37'(v1_r[45:29]) * 37'(mkh_pkg::RECIP_P);
    qm3_full = 47'(qp2_r[36:mkh_pkg::RECIP_P_SHIFT]) * 47'(mkh_pkg::PRIME_MOD);
    r4_full  = v3_r - qm3_r;
    // estimate is at most one short, so one subtract of p finishes
    if (r4_r >= 31'(mkh_pkg::PRIME_MOD)) begin
      h5_nxt = CW'(r4_r - 31'(mkh_pkg::PRIME_MOD));
    end else begin
      h5_nxt = r4_r[CW-1:0];
    end
    pl6_nxt  = 61'(h5_r) * 61'(recip[mkh_pkg::RECIP_LO_W-1:0]);
    ph7_nxt  = 60'(h6_r) * 60'(recip[mkh_pkg::RECIP_W-1:mkh_pkg::RECIP_LO_W]);
    sum8     = 61'(ph7_r) + 61'(plh7_r);
    qm9_full = 60'(q8_r) * 60'(range_limit);
    // zero range limit skips the second reduction
    if (range_limit == '0) begin
      h11_nxt = h10_r;
    end else if (r10_r >= 31'(range_limit)) begin
      h11_nxt = CW'(r10_r - 31'(range_limit));
    end else begin
      h11_nxt = r10_r[CW-1:0];
    end
    take = vld_r[NS] && active && (31'(h11_r) < sig_r.min_hash);
  end

  // control: valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      vld_r      <= '0;
    end else begin
      item_vld_r <= item_in_valid;
      vld_r      <= {vld_r[NS-1:1], item_in_valid && (item_in.cmd == mkh_pkg::CMD_TOKEN)};
    end
  end

  // running minimum
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sig_r <= mkh_pkg::EMPTY_SIG;
    end else if (ctl.shift) begin
      sig_r <= sig_in;
    end else if (take) begin
      sig_r.min_hash <= 31'(h11_r);
      sig_r.token    <= tok_r[NS];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    item_r <= item_in;
    if (item_in_valid && (item_in.cmd == mkh_pkg::CMD_LOAD) &&
        (item_in.slot_index == cell_id)) begin
      mul_r <= item_in.coef_mul;
      add_r <= item_in.coef_add;
    end
    tok_r[1] <= item_in.token;
    for (int i = 2; i <= NS; i++) begin
      tok_r[i] <= tok_r[i-1];
    end
    v1_r   <= v1_nxt;
    qp2_r  <= qp2_nxt;
    v2_r   <= v1_r[31:0];
    qm3_r  <= qm3_full[31:0];
    v3_r   <= v2_r;
    r4_r   <= r4_full[30:0];
    h5_r   <= h5_nxt;
    pl6_r  <= pl6_nxt;
    h6_r   <= h5_r;
    ph7_r  <= ph7_nxt;
    plh7_r <= pl6_r[60:31];
    h7_r   <= h6_r;
    q8_r   <= sum8[58:29];
    h8_r   <= h7_r;
    qm9_r  <= qm9_full[30:0];
    h9_r   <= h8_r;
    r10_r  <= 31'(h9_r) - qm9_r;
    h10_r  <= h9_r;
    h11_r  <= h11_nxt;
  end

  assign item_out_valid = item_vld_r;
  assign item_out       = item_r;
  assign sig_out        = sig_r;

endmodule

// ===== design/minhash_kmins_signature.sv =====
// ----------------------------------------------------------------------------
// minhash_kmins_signature
// k-mins MinHash signature over a token stream, one hashing cell per slot.
//
// Use: in_data carries either a load item (cmd = load), which sets the
// multiplier and offset of one slot, or a token item. Each item enters a
// row of MAX_HASHES cells and moves one cell per cycle; every active cell
// hashes a passing token as ((token*a+b) mod p) mod range_limit and keeps
// its minimum. Throughput: one item per cycle while in_ready is high. A
// token with last_token set closes the sequence: in_ready drops, the row
// drains, then one result per active slot leaves, slot 0 first, one per
// cycle, into the out_data register; last_of_run marks the final slot and
// all minima are cleared. out_ready low simply holds the output register
// and the readout; input stays closed until the last result is in that
// register. Reset, and every write of range_limit, start a reciprocal
// computation (one quotient bit per cycle) during which in_ready is low.
// cfg_ready is always high; config must be written by the user only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minhash_kmins_signature (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mkh_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mkh_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mkh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mkh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N     = mkh_pkg::MAX_HASHES;
  localparam int CNT_W = mkh_pkg::CNT_W;

  // configuration registers
  logic [mkh_pkg::HC_W-1:0]    hash_count_r;
  logic [mkh_pkg::RANGE_W-1:0] range_limit_r;
  logic                        cfg_fire;
  logic                        range_wr;

  // control
  mkh_pkg::state_t             state_r, state_nxt;
  logic [mkh_pkg::WAIT_W-1:0]  wait_cnt_r;
  logic [CNT_W-1:0]            rd_cnt_r;
  logic [CNT_W-1:0]            n_eff;
  logic                        in_fire;
  logic                        read_go;
  logic                        rd_last;
  logic                        div_busy;
  logic [mkh_pkg::RECIP_W-1:0] recip;
  mkh_pkg::cell_ctl_t          ctl;

  // output register
  logic                        out_valid_r;
  mkh_pkg::out_item_t          out_r;

  // cell row links
  logic                        link_v [0:N-1];
  mkh_pkg::in_item_t           link_d [0:N-1];
  mkh_pkg::sig_t               sig    [0:N-1];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign range_wr  = cfg_fire && (cfg_index == mkh_pkg::CFG_RANGE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_count_r  <= mkh_pkg::HASH_COUNT_RST;
      range_limit_r <= mkh_pkg::RANGE_LIMIT_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        mkh_pkg::CFG_HASH_COUNT:  hash_count_r  <= cfg_data[mkh_pkg::HC_W-1:0];
        mkh_pkg::CFG_RANGE_LIMIT: range_limit_r <= cfg_data[mkh_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // active slot count, clamped to 1..MAX_HASHES
  always_comb begin
    priority if (hash_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(hash_count_r) > CNT_W'(N) || hash_count_r > mkh_pkg::HC_W'(N)) begin
      n_eff = CNT_W'(N);
    end else begin
      n_eff = CNT_W'(hash_count_r);
    end
  end

  mkh_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (range_wr),
    .divisor (range_limit_r),
    .busy    (div_busy),
    .recip   (recip)
  );

  assign in_fire = in_valid && in_ready;
  assign read_go = (state_r == mkh_pkg::ST_READ) && (!out_valid_r || out_ready);
  assign rd_last = (rd_cnt_r == n_eff - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mkh_pkg::ST_RUN: begin
        if (in_fire && (in_data.cmd == mkh_pkg::CMD_TOKEN) && in_data.last_token) begin
          state_nxt = mkh_pkg::ST_WAIT;
        end
      end
      mkh_pkg::ST_WAIT: begin
        if (wait_cnt_r == '0) begin
          state_nxt = mkh_pkg::ST_READ;
        end
      end
      mkh_pkg::ST_READ: begin
        if (read_go && rd_last) begin
          state_nxt = mkh_pkg::ST_RUN;
        end
      end
      default: state_nxt = mkh_pkg::ST_RUN;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == mkh_pkg::ST_RUN) && !div_busy;
    ctl.shift = read_go;
    ctl.clear = read_go && rd_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mkh_pkg::ST_RUN;
      wait_cnt_r <= '0;
      rd_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mkh_pkg::ST_RUN) begin
        // drain time for the last token to reach the far end of the row
        wait_cnt_r <= mkh_pkg::WAIT_W'(mkh_pkg::WAIT_CYCLES);
        rd_cnt_r   <= '0;
      end else if (state_r == mkh_pkg::ST_WAIT) begin
        wait_cnt_r <= wait_cnt_r - mkh_pkg::WAIT_W'(1);
      end else if (read_go) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
    end
  end

  // output register: slot 0 of the row is always the next entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (read_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_go) begin
      out_r.out_slot        <= rd_cnt_r[mkh_pkg::SLOT_W-1:0];
      out_r.signature_token <= sig[0].token;
      out_r.min_hash        <= sig[0].min_hash;
      out_r.last_of_run     <= rd_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // row of cells; items move toward higher slots, minima shift toward slot 0
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic              cin_v;
    mkh_pkg::in_item_t cin_d;
    mkh_pkg::sig_t     sin;

    if (k == 0) begin : g_head
      assign cin_v = in_fire;
      assign cin_d = in_data;
    end else begin : g_body
      assign cin_v = link_v[k-1];
      assign cin_d = link_d[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign sin = mkh_pkg::EMPTY_SIG;
    end else begin : g_mid
      assign sin = sig[k+1];
    end

    mkh_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cell_id        (mkh_pkg::SLOT_W'(k)),
      .active         (CNT_W'(k) < n_eff),
      .range_limit    (range_limit_r),
      .recip          (recip),
      .item_in_valid  (cin_v),
      .item_in        (cin_d),
      .item_out_valid (link_v[k]),
      .item_out       (link_d[k]),
      .ctl            (ctl),
      .sig_in         (sin),
      .sig_out        (sig[k])
    );
  end

endmodule
